FILE: hw/rtl/ddo_pkg.sv
package ddo_pkg;

    localparam int unsigned WB_W = 31;
    localparam logic [WB_W-1:0] WB_RESET = 31'd19661;

    localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [63:0] QUART_PI_Q30 = 64'sd843314856;
    localparam logic signed [63:0] TWO_PI_Q28 = 64'sd1686629713;

    typedef struct packed {
        logic signed [31:0] left_position;
        logic signed [31:0] right_position;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_heading;
        logic signed [31:0] out_forward;
    } t_out_item;

    // Horner coefficients, sine polynomial (over r) and cosine polynomial
    function automatic logic signed [63:0] sin_coef(input logic [2:0] i);
        unique case (i)
            3'd0: sin_coef = 64'sd1073741824;
            3'd1: sin_coef = 64'sd178956971;
            3'd2: sin_coef = 64'sd8947849;
            3'd3: sin_coef = 64'sd213045;
            3'd4: sin_coef = 64'sd2959;
            default: sin_coef = 64'sd27;
        endcase
    endfunction

    function automatic logic signed [63:0] cos_coef(input logic [2:0] i);
        unique case (i)
            3'd0: cos_coef = 64'sd1073741824;
            3'd1: cos_coef = 64'sd536870912;
            3'd2: cos_coef = 64'sd44739243;
            3'd3: cos_coef = 64'sd1491308;
            3'd4: cos_coef = 64'sd26631;
            3'd5: cos_coef = 64'sd296;
            default: cos_coef = 64'sd2;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) sat32 = 32'h7fffffff;
        else if (v < -64'sd2147483648) sat32 = 32'h80000000;
        else sat32 = v[31:0];
    endfunction

endpackage

FILE: hw/rtl/diff_drive_odometry_core.sv
// Differential-drive odometry core.
// Each multiply or divide holds the sequencer for 64 shift steps plus start and done,
// on one bit-serial multiplier and one divider.
// Throughput: one item at a time; the next item is taken once the result is loaded.
// Reset (synchronous, active low) clears pose, previous wheel pair, forward step and
// sets wheel_base to 19661.
module diff_drive_odometry_core
    import ddo_pkg::*;
#(
    parameter logic [WB_W-1:0] P_WB_RESET = WB_RESET
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_item          i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_item         o_data,
    input  logic              i_cfg_we,
    input  logic [WB_W-1:0]   i_cfg_data
);
    // sequencer states
    localparam logic [5:0] S_IDLE = 6'd0,  S_DIFF = 6'd1,
        S_SPIN_W = 6'd3, S_ADIV_W = 6'd5, S_SINC = 6'd6,
        S_SC = 6'd7, S_SC_DW = 6'd8, S_SC_T = 6'd9, S_SC_TW = 6'd10,
        S_SP_M = 6'd11, S_SP_MW = 6'd12, S_SP_R = 6'd13, S_SP_RW = 6'd14,
        S_SC_Q = 6'd17, S_SCD = 6'd18,
        S_SCD_W = 6'd19, S_CH = 6'd22,
        S_CH_W = 6'd23, S_XM = 6'd24, S_XM_W = 6'd25, S_YM = 6'd26,
        S_YM_W = 6'd27, S_MOD = 6'd28, S_MOD_W = 6'd29, S_OUT = 6'd30,
        S_HP = 6'd32, S_HP_W = 6'd33, S_SINCS = 6'd34;

    // sin_cos callers
    localparam logic [1:0] R_STRAIGHT = 2'd0, R_SINC = 2'd1, R_ARC = 2'd2;

    logic [5:0]         r_st;
    logic [WB_W-1:0]    r_wb;
    logic signed [31:0] r_pl, r_pr, r_x, r_y, r_th, r_fw;
    logic signed [63:0] r_dl, r_dr, r_sum, r_a28, r_h30, r_xa, r_ya, r_tha;
    logic signed [63:0] r_ang, r_k, r_r, r_t, r_p, r_s, r_c, r_sinc, r_chord;
    logic [2:0]         r_i;
    logic [1:0]         r_ret;
    logic               r_cos;
    t_out_item          r_out;
    logic               r_ov;

    logic               m_start, d_start, m_done, d_done;
    logic signed [63:0] m_a, m_b, m_p, d_n, d_d, d_q, d_r;
    logic signed [63:0] n_rnd;
    logic signed [63:0] n_wb;

    ddo_mul u_mul (.i_clk, .i_rst_n, .i_start(m_start), .i_a(m_a), .i_b(m_b),
                   .o_done(m_done), .o_p(m_p));
    ddo_div u_div (.i_clk, .i_rst_n, .i_start(d_start), .i_num(d_n), .i_den(d_d),
                   .o_done(d_done), .o_quo(d_q), .o_rem(d_r));

    // product rounded from Q60 to Q30
    assign n_rnd = (m_p + 64'sd536870912) >>> 30;
    assign n_wb = (r_wb == '0) ? 64'sd1 : 64'($unsigned(r_wb));

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_wb <= P_WB_RESET;
            r_pl <= '0; r_pr <= '0; r_x <= '0; r_y <= '0; r_th <= '0; r_fw <= '0;
            r_ov <= 1'b0;
            m_start <= 1'b0;
            d_start <= 1'b0;
        end else begin
            m_start <= 1'b0;
            d_start <= 1'b0;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            if (i_cfg_we) r_wb <= i_cfg_data;
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_dl <= 64'(i_data.left_position) - 64'(r_pl);
                        r_dr <= 64'(i_data.right_position) - 64'(r_pr);
                        r_pl <= i_data.left_position;
                        r_pr <= i_data.right_position;
                        r_xa <= 64'(r_x);
                        r_ya <= 64'(r_y);
                        r_tha <= 64'(r_th);
                        r_st <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_sum <= r_dl + r_dr;
                    if (r_dl == r_dr) begin
                        r_ang <= r_tha <<< 2;
                        r_ret <= R_STRAIGHT;
                        r_chord <= r_dl;
                        r_st <= S_SC;
                    end else if (r_dl + r_dr == 64'sd0) begin
                        d_n <= r_dl <<< 28; d_d <= n_wb; d_start <= 1'b1;
                        r_st <= S_SPIN_W;
                    end else begin
                        d_n <= (r_dl - r_dr) <<< 28; d_d <= n_wb <<< 1; d_start <= 1'b1;
                        r_st <= S_ADIV_W;
                    end
                end
                S_SPIN_W: if (d_done) begin
                    r_tha <= r_tha - d_q;
                    r_st <= S_MOD;
                end
                S_ADIV_W: if (d_done) begin
                    r_a28 <= d_q;
                    r_h30 <= d_q <<< 1;
                    r_fw <= sat32(r_sum >>> 1);
                    r_st <= S_SINC;
                end
                S_SINC: begin
                    if ((r_h30 < 0 ? -r_h30 : r_h30) <= QUART_PI_Q30) begin
                        m_a <= r_h30; m_b <= r_h30; m_start <= 1'b1;
                        r_st <= S_HP_W;
                    end else begin
                        r_ang <= r_h30; r_ret <= R_SINC; r_st <= S_SC;
                    end
                end
                S_HP_W: if (m_done) begin
                    r_t <= n_rnd; r_p <= sin_coef(3'd5); r_i <= 3'd4;
                    r_cos <= 1'b0; r_ret <= R_SINC; r_st <= S_SINCS;
                end
                // sine poly only (small half angle)
                S_SINCS: begin
                    m_a <= r_t; m_b <= r_p; m_start <= 1'b1; r_st <= S_HP;
                end
                S_HP: if (m_done) begin
                    r_p <= sin_coef(r_i) - n_rnd;
                    if (r_i == 3'd0) begin
                        r_sinc <= sin_coef(r_i) - n_rnd;
                        r_st <= S_CH;
                    end else begin
                        r_i <= r_i - 3'd1;
                        r_st <= S_SINCS;
                    end
                end
                // range reduction: k = floor((x + HP/2)/HP)
                S_SC: begin
                    d_n <= r_ang + (HALF_PI_Q30 >>> 1); d_d <= HALF_PI_Q30; d_start <= 1'b1;
                    r_st <= S_SC_DW;
                end
                S_SC_DW: if (d_done) begin
                    r_k <= (d_r < 0) ? d_q - 64'sd1 : d_q;
                    r_st <= S_SC_T;
                end
                S_SC_T: begin
                    m_a <= r_k; m_b <= HALF_PI_Q30; m_start <= 1'b1; r_st <= S_SC_TW;
                end
                S_SC_TW: if (m_done) begin
                    r_r <= r_ang - m_p;
                    m_a <= r_ang - m_p; m_b <= r_ang - m_p; m_start <= 1'b1;
                    r_st <= S_SP_MW;
                end
                S_SP_MW: if (m_done) begin
                    r_t <= n_rnd; r_p <= sin_coef(3'd5); r_i <= 3'd4;
                    r_cos <= 1'b0; r_st <= S_SP_M;
                end
                // Horner over the shared multiplier, sine then cosine
                S_SP_M: begin
                    m_a <= r_t; m_b <= r_p; m_start <= 1'b1; r_st <= S_SP_R;
                end
                S_SP_R: if (m_done) begin
                    if (!r_cos) begin
                        if (r_i == 3'd0) begin
                            m_a <= r_r; m_b <= sin_coef(3'd0) - n_rnd; m_start <= 1'b1;
                            r_st <= S_SP_RW;
                        end else begin
                            r_p <= sin_coef(r_i) - n_rnd; r_i <= r_i - 3'd1;
                            r_st <= S_SP_M;
                        end
                    end else begin
                        if (r_i == 3'd0) begin
                            r_c <= cos_coef(3'd0) - n_rnd; r_st <= S_SC_Q;
                        end else begin
                            r_p <= cos_coef(r_i) - n_rnd; r_i <= r_i - 3'd1;
                            r_st <= S_SP_M;
                        end
                    end
                end
                S_SP_RW: if (m_done) begin
                    r_s <= n_rnd; r_cos <= 1'b1; r_p <= cos_coef(3'd6); r_i <= 3'd5;
                    r_st <= S_SP_M;
                end
                // quadrant select
                S_SC_Q: begin
                    unique case (r_k[1:0])
                        2'd0: begin r_s <= r_s;  r_c <= r_c;  end
                        2'd1: begin r_s <= r_c;  r_c <= -r_s; end
                        2'd2: begin r_s <= -r_s; r_c <= -r_c; end
                        default: begin r_s <= -r_c; r_c <= r_s; end
                    endcase
                    unique case (r_ret)
                        R_SINC: r_st <= S_SCD;
                        default: r_st <= S_XM;
                    endcase
                end
                S_SCD: begin
                    d_n <= r_s <<< 30; d_d <= r_h30; d_start <= 1'b1; r_st <= S_SCD_W;
                end
                S_SCD_W: if (d_done) begin
                    r_sinc <= (d_q > Q30_ONE) ? Q30_ONE : (d_q < -Q30_ONE) ? -Q30_ONE : d_q;
                    r_st <= S_CH;
                end
                // chord = round(sum*sinc / 2^31)
                S_CH: begin
                    m_a <= r_sum; m_b <= r_sinc; m_start <= 1'b1; r_st <= S_CH_W;
                end
                S_CH_W: if (m_done) begin
                    r_chord <= (m_p + 64'sd1073741824) >>> 31;
                    r_ang <= (r_tha <<< 2) + r_h30; r_ret <= R_ARC; r_st <= S_SC;
                end
                S_XM: begin
                    m_a <= r_chord; m_b <= r_c; m_start <= 1'b1; r_st <= S_XM_W;
                end
                S_XM_W: if (m_done) begin
                    r_xa <= r_xa + n_rnd; r_st <= S_YM;
                end
                S_YM: begin
                    m_a <= r_chord; m_b <= r_s; m_start <= 1'b1; r_st <= S_YM_W;
                end
                S_YM_W: if (m_done) begin
                    r_ya <= r_ya + n_rnd;
                    if (r_ret == R_ARC) r_tha <= r_tha - r_a28;
                    r_st <= S_MOD;
                end
                S_MOD: begin
                    d_n <= r_tha; d_d <= TWO_PI_Q28; d_start <= 1'b1; r_st <= S_MOD_W;
                end
                S_MOD_W: if (d_done) begin
                    r_x <= sat32(r_xa);
                    r_y <= sat32(r_ya);
                    r_th <= d_r[31:0];
                    r_st <= S_OUT;
                end
                S_OUT: if (!r_ov) begin
                    r_out.out_x <= r_x;
                    r_out.out_y <= r_y;
                    r_out.out_heading <= r_th;
                    r_out.out_forward <= r_fw;
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // a new item is never accepted while busy
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> o_stall) else $error("busy without stall");
    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data))) else $error("result lost");
    // heading stays inside (-2pi, 2pi)
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_th <= 32'sd1686629712) && (r_th >= -32'sd1686629712)) else $error("heading range");
endmodule

FILE: hw/rtl/ddo_mul.sv
// Shift-add multiplier: one bit of the multiplier per cycle, 64-bit product kept.
module ddo_mul
    import ddo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_p
);
    logic               r_busy;
    logic [6:0]         r_cnt;
    logic [63:0]        r_a;
    logic [63:0]        r_b;
    logic [63:0]        r_acc;

    // one partial product per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_b[0]) r_acc <= r_acc + r_a;
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // last partial product is already in the accumulator when done rises
    assign o_p = r_acc;
endmodule

FILE: hw/rtl/ddo_div.sv
// Restoring divider, one quotient bit per cycle, truncated toward zero.
module ddo_div
    import ddo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_quo,
    output logic signed [63:0] o_rem
);
    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_q;
    logic [63:0] r_r;
    logic [63:0] r_d;
    logic        r_nq;
    logic        r_nr;
    logic [64:0] n_trial;

    assign n_trial = {r_r, r_q[63]} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_num[63] ? 64'(-i_num) : i_num;
                r_d    <= i_den[63] ? 64'(-i_den) : i_den;
                r_r    <= '0;
                r_nq   <= i_num[63] ^ i_den[63];
                r_nr   <= i_num[63];
            end else if (r_busy) begin
                if (!n_trial[64]) begin
                    r_r <= n_trial[63:0];
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_r <= {r_r[62:0], r_q[63]};
                    r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_nq ? 64'(-r_q) : r_q;
    assign o_rem = r_nr ? 64'(-r_r) : r_r;
endmodule

FILE: tb/diff_drive_odometry_core_tb.sv
module diff_drive_odometry_core_tb;
    import ddo_pkg::*;

    // Trig constants, Q30 (two pi in Q28)
    localparam longint HP_Q30 = 64'sd1686629713;
    localparam longint QP_Q30 = 64'sd843314856;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint TWOPI_Q28 = 64'sd1686629713;
    localparam int HOLD_START = 150000;
    localparam int HOLD_LEN = 40000;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic dut_stall;
    t_in_item in_data;
    logic out_valid;
    logic out_stall;
    t_out_item out_data;
    logic cfg_we;
    logic [WB_W-1:0] cfg_data;

    diff_drive_odometry_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(in_valid),
        .o_stall(dut_stall),
        .i_data(in_data),
        .o_valid(out_valid),
        .i_stall(out_stall),
        .o_data(out_data),
        .i_cfg_we(cfg_we),
        .i_cfg_data(cfg_data)
    );

    // Pending wheel samples and expected poses
    t_in_item sample_q[$];
    t_out_item pose_q[$];
    bit failed = 0;

    // Predictor state
    logic [WB_W-1:0] base_len;
    logic signed [31:0] last_l, last_r, pos_x, pos_y, head, fwd;

    // Generator's own copy of the wheel positions
    logic signed [31:0] gen_l, gen_r;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint rnd_shift(longint v, int n);
        rnd_shift = (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint qmul(longint a, longint b);
        qmul = rnd_shift(a * b, 30);
    endfunction

    function automatic longint sinc_poly(longint t);
        longint c[6];
        longint p;
        c = '{64'sd1073741824, 64'sd178956971, 64'sd8947849, 64'sd213045, 64'sd2959, 64'sd27};
        p = c[5];
        for (int i = 4; i >= 0; i--) p = c[i] - qmul(t, p);
        sinc_poly = p;
    endfunction

    function automatic longint cos_poly(longint t);
        longint c[7];
        longint p;
        c = '{64'sd1073741824, 64'sd536870912, 64'sd44739243, 64'sd1491308, 64'sd26631,
              64'sd296, 64'sd2};
        p = c[6];
        for (int i = 5; i >= 0; i--) p = c[i] - qmul(t, p);
        cos_poly = p;
    endfunction

    // Quadrant reduction then polynomial sine/cosine
    task automatic trig(input longint ang, output longint sv, output longint cv);
        longint n, k, r, t, s, c;
        n = ang + HP_Q30 / 2;
        k = n / HP_Q30;
        if (n % HP_Q30 < 0) k--;
        r = ang - k * HP_Q30;
        t = qmul(r, r);
        s = qmul(r, sinc_poly(t));
        c = cos_poly(t);
        case (k & 3)
            0: begin sv = s; cv = c; end
            1: begin sv = c; cv = -s; end
            2: begin sv = -s; cv = -c; end
            default: begin sv = -c; cv = s; end
        endcase
    endtask

    task automatic sinc_of(input longint h, output longint v);
        longint m, s, c;
        m = h < 0 ? -h : h;
        if (m <= QP_Q30) begin
            v = sinc_poly(qmul(h, h));
        end else begin
            trig(h, s, c);
            v = (s * ONE_Q30) / h;
        end
        if (v > ONE_Q30) v = ONE_Q30;
        if (v < -ONE_Q30) v = -ONE_Q30;
    endtask

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) clamp32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648) clamp32 = 32'sh80000000;
        else clamp32 = v[31:0];
    endfunction

    // Pose update for one accepted wheel sample
    task automatic odom_update(input t_in_item it);
        longint dl, dr, th, wb, x, y, s, c, sum, a28, h30, sc, chord;
        t_out_item res;
        dl = longint'(it.left_position) - longint'(last_l);
        dr = longint'(it.right_position) - longint'(last_r);
        th = head;
        wb = (base_len == 0) ? 1 : longint'(base_len);
        x = pos_x;
        y = pos_y;
        if (dl == dr) begin
            trig(th * 4, s, c);
            x += rnd_shift(dl * c, 30);
            y += rnd_shift(dl * s, 30);
        end else if (dl + dr == 0) begin
            th -= (dl * 64'sd268435456) / wb;
        end else begin
            sum = dl + dr;
            a28 = ((dl - dr) * 64'sd268435456) / (2 * wb);
            h30 = a28 * 2;
            sinc_of(h30, sc);
            chord = rnd_shift(sum * sc, 31);
            fwd = clamp32(sum >>> 1);
            trig(th * 4 + h30, s, c);
            x += rnd_shift(chord * c, 30);
            y += rnd_shift(chord * s, 30);
            th -= a28;
        end
        pos_x = clamp32(x);
        pos_y = clamp32(y);
        th = th % TWOPI_Q28;
        head = th[31:0];
        last_l = it.left_position;
        last_r = it.right_position;
        res.out_x = pos_x;
        res.out_y = pos_y;
        res.out_heading = head;
        res.out_forward = fwd;
        pose_q.push_back(res);
    endtask

    // Driver: bursts of items with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !dut_stall) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                in_data <= sample_q.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off
    int cyc = 0;
    int stall_mode = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc % 5000 == 0) stall_mode <= $urandom_range(0, 3);
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
            out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // Monitor: predict on accepted samples, check on accepted poses
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (in_valid && !dut_stall) odom_update(in_data);
            if (out_valid && !out_stall) begin
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected pose x=%0d y=%0d h=%0d f=%0d", $time,
                             out_data.out_x, out_data.out_y, out_data.out_heading,
                             out_data.out_forward);
                    failed = 1;
                end else begin
                    want = pose_q.pop_front();
                    if (want.out_x !== out_data.out_x) begin
                        $display("%0t: out_x expected %0d actual %0d", $time,
                                 want.out_x, out_data.out_x);
                        failed = 1;
                    end
                    if (want.out_y !== out_data.out_y) begin
                        $display("%0t: out_y expected %0d actual %0d", $time,
                                 want.out_y, out_data.out_y);
                        failed = 1;
                    end
                    if (want.out_heading !== out_data.out_heading) begin
                        $display("%0t: out_heading expected %0d actual %0d", $time,
                                 want.out_heading, out_data.out_heading);
                        failed = 1;
                    end
                    if (want.out_forward !== out_data.out_forward) begin
                        $display("%0t: out_forward expected %0d actual %0d", $time,
                                 want.out_forward, out_data.out_forward);
                        failed = 1;
                    end
                end
            end
        end
    end

    // Queue a sample with the given wheel steps (positions wrap at 32 bits)
    task automatic push_step(input logic signed [31:0] dl, input logic signed [31:0] dr);
        t_in_item it;
        gen_l = gen_l + dl;
        gen_r = gen_r + dr;
        it.left_position = gen_l;
        it.right_position = gen_r;
        sample_q.push_back(it);
    endtask

    task automatic push_abs(input logic signed [31:0] l, input logic signed [31:0] r);
        t_in_item it;
        gen_l = l;
        gen_r = r;
        it.left_position = l;
        it.right_position = r;
        sample_q.push_back(it);
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || in_valid || pose_q.size() > 0) @(posedge i_clk);
        repeat (3500) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [WB_W-1:0] v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        base_len = v;
    endtask

    // Mostly well-formed motion with random content, some wild jumps
    task automatic random_motion(input int n);
        logic signed [31:0] d, e;
        for (int i = 0; i < n; i++) begin
            d = $urandom_range(0, 1) ? $signed($urandom_range(0, 262144)) - 131072
                                      : $signed($urandom_range(0, 2047)) - 1024;
            e = $signed($urandom_range(0, 65535)) - 32768;
            case ($urandom_range(0, 9))
                0, 1: push_step(d, d);
                2, 3: push_step(d, -d);
                4, 5, 6: push_step(d, d + e);
                7: push_step($urandom, $urandom);
                8: push_abs($urandom, $urandom);
                default: push_step(d, $signed($urandom_range(0, 262144)) - 131072);
            endcase
        end
    endtask

    initial begin
        i_rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        cfg_we = 0;
        cfg_data = '0;
        base_len = WB_RESET;
        last_l = 0; last_r = 0; pos_x = 0; pos_y = 0; head = 0; fwd = 0;
        gen_l = 0; gen_r = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: no motion, straight, spin, arc, extreme jumps and headings
        push_step(0, 0);
        push_step(32'sd65536, 32'sd65536);
        push_step(32'sd65536, -32'sd65536);
        push_step(32'sd131072, 32'sd65536);
        push_step(-32'sd65536, 32'sd196608);
        push_abs(32'sh7fffffff, 32'sh7fffffff);
        push_abs(32'sh80000000, 32'sh80000000);
        push_abs(32'sh7fffffff, 32'sh80000000);
        push_abs(32'sh80000000, 32'sh7fffffff);
        push_abs(32'sh7fffffff, 32'sh7fffffff);
        push_abs(0, 0);
        push_step(32'sd1000000, -32'sd1000000);
        push_step(32'sd2000000, 32'sd2000000);
        push_step(32'sd1, 32'sd2);
        push_step(32'sd5000, 32'sd5003);
        push_step(32'sh40000000, 32'sh40000000);
        push_step(32'sh40000000, 32'sh40000000);
        push_step(32'sh40000000, 32'sh40000000);
        push_step(-32'sd50000, 32'sd70000);
        random_motion(240);
        drain();

        write_base('0);
        push_step(32'sd1, -32'sd1);
        push_abs(32'sh7fffffff, 32'sh80000000);
        push_step(32'sd3, 32'sd1);
        random_motion(250);
        drain();

        write_base(31'd1);
        random_motion(250);
        drain();

        write_base(31'h7fffffff);
        push_step(32'sh7fffffff, 32'sh7fffffff);
        push_abs(32'sh80000000, 32'sh7fffffff);
        random_motion(250);
        drain();

        write_base(31'($urandom_range(1000, 200000)));
        random_motion(280);
        drain();

        if (!failed) begin
            $display("diff_drive_odometry_core: match");
        end else begin
            $display("diff_drive_odometry_core: mismatch");
        end
        $finish;
    end

    initial begin
        #400000000;
        $display("diff_drive_odometry_core: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_mul.sv
hw/rtl/ddo_div.sv
hw/rtl/diff_drive_odometry_core.sv
tb/diff_drive_odometry_core_tb.sv
